// ----- design/rlfs_pkg.sv -----
// ----------------------------------------------------------------------------
// rlfs_pkg
// Shared constants and register codes for the radial light falloff shader.
// ----------------------------------------------------------------------------
`default_nettype none

package rlfs_pkg;

	// Default widths of coordinates and of the intensity fraction
	localparam int COORD_BITS_DEF = 11;
	localparam int FRAC_BITS_DEF  = 16;

	// Fraction bits of the distance (Q.8)
	localparam int DIST_FRAC = 8;

	// Configuration port
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int BRIGHT_BITS   = 8;
	localparam int GRAY_BITS     = 8;

	// Register reset values
	localparam int RADIUS_RESET = 1250;
	localparam int BRIGHT_RESET = 250;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_LIGHT_X          = 2'd0,
		REG_LIGHT_Y          = 2'd1,
		REG_LIGHT_RADIUS     = 2'd2,
		REG_LIGHT_BRIGHTNESS = 2'd3
	} cfg_reg_t;

endpackage

`default_nettype wire

// ----- design/rlfs_pix_if.sv -----
// ----------------------------------------------------------------------------
// rlfs_pix_if
// Pixel coordinate channel: valid/ready handshake with x and y payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlfs_pix_if #(
	parameter int COORD_BITS = rlfs_pkg::COORD_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

// ----- design/rlfs_shade_if.sv -----
// ----------------------------------------------------------------------------
// rlfs_shade_if
// Shade result channel: valid/ready handshake with lit flag and gray level.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlfs_shade_if;
	logic                           valid;
	logic                           ready;
	logic                           lit;
	logic [rlfs_pkg::GRAY_BITS-1:0] gray_level;

	modport source (output valid, output lit, output gray_level, input ready);
	modport sink   (input valid, input lit, input gray_level, output ready);
endinterface

`default_nettype wire

// ----- design/rlfs_cfg_if.sv -----
// ----------------------------------------------------------------------------
// rlfs_cfg_if
// Configuration write channel: valid/ready handshake with index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlfs_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [rlfs_pkg::CFG_IDX_BITS-1:0]  index;
	logic [rlfs_pkg::CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/rlfs_isqrt.sv -----
// ----------------------------------------------------------------------------
// rlfs_isqrt
// Pipelined integer square root, one result bit per stage, with a lit flag
// carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module rlfs_isqrt #(
	parameter int RW = 19
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire logic            in_lit,
	input  wire logic [2*RW-1:0] in_rad,
	output logic                 out_valid,
	output logic                 out_lit,
	output logic [RW-1:0]        out_root
);
	logic            v_s    [RW];
	logic            lit_s  [RW];
	logic [RW:0]     rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [2*RW-1:0] rad_s  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic            cur_v;
		logic            cur_lit;
		logic [RW:0]     cur_rem;
		logic [RW-1:0]   cur_root;
		logic [2*RW-1:0] cur_rad;
		logic [RW+1:0]   acc;
		logic [RW+1:0]   trial;
		logic            ge;
		logic [RW+1:0]   diff;

		if (k == 0) begin : g_first
			assign cur_v    = in_valid;
			assign cur_lit  = in_lit;
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_rad  = in_rad;
		end else begin : g_next
			assign cur_v    = v_s[k-1];
			assign cur_lit  = lit_s[k-1];
			assign cur_rem  = rem_s[k-1];
			assign cur_root = root_s[k-1];
			assign cur_rad  = rad_s[k-1];
		end

		// Bring down the next two radicand bits and try root*4+1
		assign acc   = {cur_rem[RW-1:0], cur_rad[2*RW-1 -: 2]};
		assign trial = {cur_root, 2'b01};
		assign ge    = (acc >= trial);
		assign diff  = acc - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lit_s[k]  <= cur_lit;
				rem_s[k]  <= ge ? diff[RW:0] : acc[RW:0];
				root_s[k] <= {cur_root[RW-2:0], ge};
				rad_s[k]  <= {cur_rad[2*RW-3:0], 2'b00};
			end
		end
	end

	assign out_valid = v_s[RW-1];
	assign out_lit   = lit_s[RW-1];
	assign out_root  = root_s[RW-1];

endmodule

`default_nettype wire

// ----- design/rlfs_div.sv -----
// ----------------------------------------------------------------------------
// rlfs_div
// Pipelined restoring divider: (num << (QW-1)) / den for num <= den,
// one quotient bit per stage, with a lit flag carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module rlfs_div #(
	parameter int DW = 19,
	parameter int QW = 17
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic [DW-1:0] den,
	input  wire logic          in_valid,
	input  wire logic          in_lit,
	input  wire logic [DW-1:0] in_num,
	output logic               out_valid,
	output logic               out_lit,
	output logic [QW-1:0]      out_quo
);
	logic          v_s   [QW];
	logic          lit_s [QW];
	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] quo_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic          cur_v;
		logic          cur_lit;
		logic [DW:0]   acc;
		logic [QW-1:0] cur_quo;
		logic          ge;
		logic [DW:0]   diff;

		// First stage takes the numerator as is; later ones shift the remainder
		if (k == 0) begin : g_first
			assign cur_v   = in_valid;
			assign cur_lit = in_lit;
			assign acc     = {1'b0, in_num};
			assign cur_quo = '0;
		end else begin : g_next
			assign cur_v   = v_s[k-1];
			assign cur_lit = lit_s[k-1];
			assign acc     = {rem_s[k-1], 1'b0};
			assign cur_quo = quo_s[k-1];
		end

		assign ge   = (acc >= {1'b0, den});
		assign diff = acc - {1'b0, den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lit_s[k] <= cur_lit;
				rem_s[k] <= ge ? diff[DW-1:0] : acc[DW-1:0];
				quo_s[k] <= {cur_quo[QW-2:0], ge};
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign out_lit   = lit_s[QW-1];
	assign out_quo   = quo_s[QW-1];

endmodule

`default_nettype wire

// ----- design/radial_light_falloff_shader_core.sv -----
// ----------------------------------------------------------------------------
// radial_light_falloff_shader_core
// Shades pixel coordinates against a point light with radial falloff.
// ----------------------------------------------------------------------------
// Usage:
//   pix   : one pixel coordinate (pixel_x, pixel_y) per transaction.
//   shade : one result (lit, gray_level) per pixel transaction, in order.
//   cfg   : register writes (0 light_x, 1 light_y, 2 light_radius,
//           3 light_brightness); always ready, write only while idle.
// Throughput: one pixel per cycle when the receiver keeps ready high.
// Pipeline: three front stages (offset, squares, sum and disc test), one
//   square root stage per root bit, one subtract stage, one divider stage
//   per quotient bit, then the falloff stage and the output register.
// Stall: the whole pipeline holds while the output register is full and
//   shade.ready is low; pix.ready drops for as long as that lasts.
// Reset: clears all valid bits and loads the register reset values
//   (light at 0,0, radius 1250, brightness 250).
// ----------------------------------------------------------------------------
`default_nettype none

module radial_light_falloff_shader_core #(
	parameter int COORD_BITS = rlfs_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = rlfs_pkg::FRAC_BITS_DEF
) (
	input wire logic        clk,
	input wire logic        arst_n,
	rlfs_pix_if.sink        pix,
	rlfs_shade_if.source    shade,
	rlfs_cfg_if.sink        cfg
);
	import rlfs_pkg::*;

	localparam int C      = COORD_BITS;
	localparam int RW     = COORD_BITS + DIST_FRAC;
	localparam int QW     = FRAC_BITS + 1;
	localparam int PW     = BRIGHT_BITS + QW;
	localparam int THRESH = (99 * (1 << FRAC_BITS)) / 100;
	localparam int RAD_RST = RADIUS_RESET % (1 << COORD_BITS);

	// Configuration registers
	logic [C-1:0]           light_x_q;
	logic [C-1:0]           light_y_q;
	logic [C-1:0]           light_radius_q;
	logic [BRIGHT_BITS-1:0] light_bright_q;
	logic [2*C-1:0]         radius_sq_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q      <= '0;
			light_y_q      <= '0;
			light_radius_q <= C'(RAD_RST);
			light_bright_q <= BRIGHT_BITS'(BRIGHT_RESET);
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_LIGHT_X:          light_x_q      <= cfg.data[C-1:0];
				REG_LIGHT_Y:          light_y_q      <= cfg.data[C-1:0];
				REG_LIGHT_RADIUS:     light_radius_q <= cfg.data[C-1:0];
				REG_LIGHT_BRIGHTNESS: light_bright_q <= cfg.data[BRIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		radius_sq_q <= {{C{1'b0}}, light_radius_q} * {{C{1'b0}}, light_radius_q};
	end

	// Global advance: move when the output register is empty or being taken
	logic en;
	assign en        = !shade.valid || shade.ready;
	assign pix.ready = en;

	// Stage 1: offsets, square test, magnitudes
	logic signed [C:0] dx;
	logic signed [C:0] dy;
	logic signed [C:0] r_sgn;
	logic [C:0]        dx_neg;
	logic [C:0]        dy_neg;
	logic              in_sq;

	assign dx     = $signed({1'b0, pix.pixel_x}) - $signed({1'b0, light_x_q});
	assign dy     = $signed({1'b0, pix.pixel_y}) - $signed({1'b0, light_y_q});
	assign r_sgn  = $signed({1'b0, light_radius_q});
	assign dx_neg = -dx;
	assign dy_neg = -dy;
	assign in_sq  = (dx >= -r_sgn) && (dx < r_sgn) && (dy >= -r_sgn) && (dy < r_sgn);

	logic         v_s1;
	logic         in_sq_s1;
	logic [C-1:0] ux_s1;
	logic [C-1:0] uy_s1;

	// Stage 2: squares
	logic         v_s2;
	logic         in_sq_s2;
	logic [2*C-1:0] sqx_s2;
	logic [2*C-1:0] sqy_s2;

	// Stage 3: squared distance and disc test
	logic [2*C:0] dist2;
	assign dist2 = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	logic           v_s3;
	logic           lit_s3;
	logic [2*C-1:0] dist2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_sq_s1 <= in_sq;
			ux_s1    <= dx[C] ? dx_neg[C-1:0] : dx[C-1:0];
			uy_s1    <= dy[C] ? dy_neg[C-1:0] : dy[C-1:0];
			in_sq_s2 <= in_sq_s1;
			sqx_s2   <= {{C{1'b0}}, ux_s1} * {{C{1'b0}}, ux_s1};
			sqy_s2   <= {{C{1'b0}}, uy_s1} * {{C{1'b0}}, uy_s1};
			lit_s3   <= in_sq_s2 && (dist2 <= {1'b0, radius_sq_q})
				&& (light_radius_q != '0);
			dist2_s3 <= dist2[2*C-1:0];
		end
	end

	// Square root of dist2 scaled to Q.DIST_FRAC
	logic          sq_v;
	logic          sq_lit;
	logic [RW-1:0] sq_root;

	rlfs_isqrt #(
		.RW(RW)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_lit    (lit_s3),
		.in_rad    ({dist2_s3, {(2*DIST_FRAC){1'b0}}}),
		.out_valid (sq_v),
		.out_lit   (sq_lit),
		.out_root  (sq_root)
	);

	// Stage 4: remaining distance r - d, clamped at zero
	logic [RW-1:0] rq;
	assign rq = {light_radius_q, {DIST_FRAC{1'b0}}};

	logic          v_s4;
	logic          lit_s4;
	logic [RW-1:0] num_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lit_s4 <= sq_lit;
			num_s4 <= (sq_root > rq) ? '0 : (rq - sq_root);
		end
	end

	// Intensity (r - d) / r in Q1.FRAC_BITS
	logic          dv_v;
	logic          dv_lit;
	logic [QW-1:0] dv_quo;

	rlfs_div #(
		.DW(RW),
		.QW(QW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.den       (rq),
		.in_valid  (v_s4),
		.in_lit    (lit_s4),
		.in_num    (num_s4),
		.out_valid (dv_v),
		.out_lit   (dv_lit),
		.out_quo   (dv_quo)
	);

	// Stage 5: halve the intensity below the 0.99 mark
	logic          v_s5;
	logic          lit_s5;
	logic [QW-1:0] inten_s5;

	// Stage 6: scale by brightness into the output register
	logic [PW-1:0]        prod;
	logic [PW-FRAC_BITS-1:0] gray_full;
	logic [GRAY_BITS-1:0] gray;

	assign prod      = {{QW{1'b0}}, light_bright_q} * {{BRIGHT_BITS{1'b0}}, inten_s5};
	assign gray_full = prod[PW-1:FRAC_BITS];
	assign gray      = (gray_full > (PW-FRAC_BITS)'(255)) ? GRAY_BITS'(255)
		: gray_full[GRAY_BITS-1:0];

	logic                 v_s6;
	logic                 lit_s6;
	logic [GRAY_BITS-1:0] gray_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv_v;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lit_s5   <= dv_lit;
			inten_s5 <= (dv_quo < QW'(THRESH)) ? {1'b0, dv_quo[QW-1:1]} : dv_quo;
			lit_s6   <= lit_s5;
			gray_s6  <= lit_s5 ? gray : '0;
		end
	end

	assign shade.valid      = v_s6;
	assign shade.lit        = lit_s6;
	assign shade.gray_level = gray_s6;

endmodule

`default_nettype wire

// ----- tb/radial_light_falloff_shader_core_tb.sv -----
// ----------------------------------------------------------------------------
// radial_light_falloff_shader_core_tb
// Drives pixel coordinates through the shader under a series of light
// settings and compares every shade result with an in-order prediction of
// the disc test, the square-root distance and the clipped falloff.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_light_falloff_shader_core_tb;
	import rlfs_pkg::*;

	localparam int COORD_BITS   = COORD_BITS_DEF;
	localparam int FRAC_BITS    = FRAC_BITS_DEF;
	localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
	localparam int PIPE_LATENCY = COORD_BITS + FRAC_BITS + 15;
	localparam int N_PHASES     = 10;
	localparam int PHASE_ITEMS  = 170;
	// intensity below 0.99 in Q1.FRAC_BITS is halved
	localparam longint unsigned FALLOFF_KNEE = (longint'(99) << FRAC_BITS) / 100;

	typedef struct packed {
		logic                 lit;
		logic [GRAY_BITS-1:0] gray_level;
	} shade_t;

	class shade_scoreboard;
		logic [COORD_BITS-1:0]  light_x;
		logic [COORD_BITS-1:0]  light_y;
		logic [COORD_BITS-1:0]  light_radius;
		logic [BRIGHT_BITS-1:0] light_brightness;
		shade_t                 pending_shades[$];
		int                     n_errors;
		int                     n_pixels;
		int                     n_lit;

		function new();
			light_x          = '0;
			light_y          = '0;
			light_radius     = COORD_BITS'(RADIUS_RESET);
			light_brightness = BRIGHT_BITS'(BRIGHT_RESET);
			n_errors         = 0;
			n_pixels         = 0;
			n_lit            = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				REG_LIGHT_X:          light_x          = data[COORD_BITS-1:0];
				REG_LIGHT_Y:          light_y          = data[COORD_BITS-1:0];
				REG_LIGHT_RADIUS:     light_radius     = data[COORD_BITS-1:0];
				REG_LIGHT_BRIGHTNESS: light_brightness = data[BRIGHT_BITS-1:0];
				default: ;
			endcase
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned root;
			longint unsigned probe;
			root  = 0;
			probe = 64'd1 << 62;
			while (probe > v)
				probe >>= 2;
			while (probe != 0) begin
				if (v >= root + probe) begin
					v    -= root + probe;
					root  = (root >> 1) + probe;
				end else begin
					root >>= 1;
				end
				probe >>= 2;
			end
			return root;
		endfunction

		function shade_t shade_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
			longint          r;
			longint          dx;
			longint          dy;
			longint unsigned ux;
			longint unsigned uy;
			longint unsigned dist2;
			longint unsigned d;
			longint unsigned rq;
			longint unsigned inten;
			longint unsigned gray;
			shade_t          s;
			s  = '0;
			r  = longint'(light_radius);
			dx = longint'(px) - longint'(light_x);
			dy = longint'(py) - longint'(light_y);
			// half-open square first, then the disc
			if (dx >= -r && dx < r && dy >= -r && dy < r) begin
				ux    = (dx < 0) ? -dx : dx;
				uy    = (dy < 0) ? -dy : dy;
				dist2 = ux * ux + uy * uy;
				if (r != 0 && dist2 <= longint'(r * r)) begin
					d  = int_sqrt(dist2 << (2 * DIST_FRAC));
					rq = longint'(r) << DIST_FRAC;
					if (d > rq)
						d = rq;
					inten = ((rq - d) << FRAC_BITS) / rq;
					if (inten < FALLOFF_KNEE)
						inten >>= 1;
					gray = (longint'(light_brightness) * inten) >> FRAC_BITS;
					if (gray > 255)
						gray = 255;
					s.lit        = 1'b1;
					s.gray_level = gray[GRAY_BITS-1:0];
				end
			end
			return s;
		endfunction

		function void note_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
			pending_shades.push_back(shade_pixel(px, py));
			n_pixels++;
		endfunction

		task report_mismatch(string msg);
			n_errors++;
			if (n_errors <= 40)
				$display("MISMATCH @%0t: %s", $realtime, msg);
		endtask

		task check_shade(logic lit, logic [GRAY_BITS-1:0] gray_level);
			shade_t want;
			if (pending_shades.size() == 0) begin
				report_mismatch($sformatf("unexpected shade lit=%0d gray=%0d", lit, gray_level));
			end else begin
				want = pending_shades.pop_front();
				if (lit !== want.lit)
					report_mismatch($sformatf("lit %0d, predicted %0d", lit, want.lit));
				if (gray_level !== want.gray_level)
					report_mismatch($sformatf("gray_level %0d, predicted %0d",
						gray_level, want.gray_level));
				if (want.lit)
					n_lit++;
			end
		endtask

		function int pending();
			return pending_shades.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   stall_pct;
	int   n_settings;

	shade_scoreboard sb = new();

	rlfs_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch();
	rlfs_shade_if shade_ch();
	rlfs_cfg_if cfg_ch();

	radial_light_falloff_shader_core #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pix   (pix_ch),
		.shade (shade_ch),
		.cfg   (cfg_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// receiver stalls
	always @(posedge clk) begin
		shade_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && cfg_ch.valid && cfg_ch.ready)
			sb.write_reg(cfg_reg_t'(cfg_ch.index), cfg_ch.data);
		if (arst_n && pix_ch.valid && pix_ch.ready)
			sb.note_pixel(pix_ch.pixel_x, pix_ch.pixel_y);
		if (arst_n && shade_ch.valid && shade_ch.ready)
			sb.check_shade(shade_ch.lit, shade_ch.gray_level);
	end

	task automatic push_pixel(input int unsigned x, input int unsigned y);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid   <= 1'b1;
		pix_ch.pixel_x <= COORD_BITS'(x);
		pix_ch.pixel_y <= COORD_BITS'(y);
		do @(posedge clk); while (!pix_ch.ready);
	endtask

	// hold the sender until every shade is back, then let the pipe empty
	task automatic drain_pipe();
		pix_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic set_light(input logic [CFG_DATA_BITS-1:0] x, input logic [CFG_DATA_BITS-1:0] y,
		input logic [CFG_DATA_BITS-1:0] r, input logic [CFG_DATA_BITS-1:0] b);
		write_reg(REG_LIGHT_X, x);
		write_reg(REG_LIGHT_Y, y);
		write_reg(REG_LIGHT_RADIUS, r);
		write_reg(REG_LIGHT_BRIGHTNESS, b);
		cfg_ch.valid <= 1'b0;
		n_settings++;
		@(posedge clk);
	endtask

	function automatic int unsigned near_coord(int unsigned c, int unsigned r);
		int lo;
		int hi;
		lo = int'(c) - int'(r);
		hi = int'(c) + int'(r);
		if (lo < 0)
			lo = 0;
		if (hi > COORD_MAX)
			hi = COORD_MAX;
		return $urandom_range(hi, lo);
	endfunction

	initial begin
		int unsigned lx;
		int unsigned ly;
		int unsigned lr;
		int unsigned lb;
		int unsigned px;
		int unsigned py;

		arst_n         = 1'b0;
		send_idle_pct  = 15;
		stall_pct      = 15;
		n_settings     = 1;
		pix_ch.valid   = 1'b0;
		pix_ch.pixel_x = '0;
		pix_ch.pixel_y = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = REG_LIGHT_X;
		cfg_ch.data    = '0;
		shade_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset light: centre, edge of the square, corner of the disc
		push_pixel(0, 0);
		push_pixel(1249, 0);
		push_pixel(1250, 0);
		push_pixel(0, 1249);
		push_pixel(883, 883);
		push_pixel(884, 884);
		push_pixel(COORD_MAX, COORD_MAX);
		drain_pipe();

		// radius 100: falloff knee, rim at distance r, square edges
		set_light(1000, 1000, 100, 255);
		push_pixel(1000, 1000);
		push_pixel(1001, 1000);
		push_pixel(1002, 1000);
		push_pixel(1100, 1000);
		push_pixel(1000, 1100);
		push_pixel(900, 1000);
		push_pixel(1000, 900);
		push_pixel(899, 1000);
		push_pixel(1070, 1070);
		push_pixel(1071, 1071);
		drain_pipe();

		// all-ones data: register masks give the largest light
		set_light(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_pixel(COORD_MAX, COORD_MAX);
		push_pixel(0, 0);
		push_pixel(0, COORD_MAX);
		push_pixel(1, COORD_MAX);
		drain_pipe();

		// radius masked to zero: nothing lit
		set_light(5, 5, 16'h0800, 255);
		push_pixel(5, 5);
		push_pixel(4, 4);
		drain_pipe();

		// zero brightness: lit but black
		set_light(500, 500, 300, 16'h0100);
		push_pixel(500, 500);
		drain_pipe();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			lx = $urandom_range(COORD_MAX, 0);
			ly = $urandom_range(COORD_MAX, 0);
			lb = $urandom_range(255, 0);
			case (ph)
				0: lr = $urandom_range(16, 1);
				1: begin
					lr = COORD_MAX;
					lx = 0;
					ly = COORD_MAX;
				end
				2: begin
					lr = 1;
					lx = COORD_MAX;
					ly = 0;
				end
				default: lr = $urandom_range(COORD_MAX, 1);
			endcase
			if (ph == 4)
				lb = 0;
			if (ph == 5)
				lb = 255;
			// long stretch without any idling on either side
			send_idle_pct = (ph == 3) ? 0 : 15;
			stall_pct     = (ph == 3) ? 0 : 15;
			// random upper data bits must be dropped by the registers
			set_light(16'(lx) | (16'($urandom) & 16'hF800),
				16'(ly) | (16'($urandom) & 16'hF800),
				16'(lr) | (16'($urandom) & 16'hF800),
				16'(lb) | (16'($urandom) & 16'hFF00));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(99) < 85) begin
					px = near_coord(lx, lr);
					py = near_coord(ly, lr);
				end else begin
					px = $urandom_range(COORD_MAX, 0);
					py = $urandom_range(COORD_MAX, 0);
				end
				push_pixel(px, py);
			end
			drain_pipe();
		end

		$display("Shaded %0d pixels (%0d lit) under %0d light settings,",
			sb.n_pixels, sb.n_lit, n_settings);
		$display("covering register masks, zero radius and brightness, and disc edges.");
		if (sb.n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
